// ===== design/vc1_pkg.sv =====
// shared constants and types for the valid 1-d convolution core
// no dependencies; compiled first
package vc1_pkg;

    localparam int MAX_TAPS_DEF    = 16;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_BITS        = 5;
    localparam int TAP_BITS        = 4;
    localparam int RESULT_BITS     = 36;
    localparam int POS_BITS        = 16;
    localparam int SEEN_BITS       = 17;

    // per-cycle control broadcast to every cell of the tap chain
    typedef struct packed {
        logic load;   // sample request accepted: shift history, take window copy
        logic clear;  // accepted sample ends the frame: zero the history
        logic align;  // move the window copy one cell up
    } t_cell_ctl;

endpackage

// ===== design/vc1_if.sv =====
// request and result channel interfaces of the valid 1-d convolution core
// depends on vc1_pkg
interface vc1_in_if #(
    parameter int SAMPLE_BITS = vc1_pkg::SAMPLE_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic                             func;
    logic [vc1_pkg::TAP_BITS-1:0]     tap_index;
    logic signed [SAMPLE_BITS-1:0]    value;
    logic                             frame_last;

    modport source (output valid, func, tap_index, value, frame_last, input ready);
    modport sink   (input valid, func, tap_index, value, frame_last, output ready);
endinterface

interface vc1_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [vc1_pkg::RESULT_BITS-1:0] result;
    logic [vc1_pkg::POS_BITS-1:0]         out_position;
    logic                                 out_last;

    modport source (output valid, result, out_position, out_last, input ready);
    modport sink   (input valid, result, out_position, out_last, output ready);
endinterface

// ===== design/vc1_cell.sv =====
// one tap cell: history sample, window copy, weight, product and partial sum
// depends on vc1_pkg
module vc1_cell #(
    parameter int SAMPLE_BITS = vc1_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  vc1_pkg::t_cell_ctl                     i_ctl,
    input  logic                                   i_w_we,
    input  logic signed [SAMPLE_BITS-1:0]          i_w_data,
    input  logic signed [SAMPLE_BITS-1:0]          i_s_prev,
    input  logic signed [SAMPLE_BITS-1:0]          i_c_prev,
    input  logic signed [vc1_pkg::RESULT_BITS-1:0] i_psum_prev,
    output logic signed [SAMPLE_BITS-1:0]          o_s,
    output logic signed [SAMPLE_BITS-1:0]          o_c,
    output logic signed [vc1_pkg::RESULT_BITS-1:0] o_psum
);
    localparam int RW = vc1_pkg::RESULT_BITS;

    logic signed [SAMPLE_BITS-1:0]   r_s;
    logic signed [SAMPLE_BITS-1:0]   r_w;
    logic signed [SAMPLE_BITS-1:0]   r_c;
    logic signed [RW-1:0]            r_p;
    logic signed [RW-1:0]            r_psum;
    logic signed [2*SAMPLE_BITS-1:0] prod;

    assign prod = r_c * r_w;

    // history and weights are architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
            r_w <= '0;
        end else begin
            if (i_ctl.load) begin
                r_s <= i_ctl.clear ? '0 : i_s_prev;
            end
            if (i_w_we) begin
                r_w <= i_w_data;
            end
        end
    end

    // window copy, product and partial sum run freely
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_c <= i_s_prev;
        end else if (i_ctl.align) begin
            r_c <= i_c_prev;
        end
        r_p    <= RW'(prod);
        r_psum <= i_psum_prev + r_p;
    end

    assign o_s    = r_s;
    assign o_c    = r_c;
    assign o_psum = r_psum;
endmodule

// ===== design/valid_convolution_1d_core.sv =====
// top level of the valid 1-d convolution core: control, tap cell chain, result register
// depends on vc1_pkg, vc1_if (vc1_in_if, vc1_out_if) and vc1_cell
//
//  port        dir   kind       carries
//  i_in        in    channel    weight load or sample request
//  o_out       out   channel    result, out_position, out_last
//  i_cfg_*     in    write      num_taps register
//
//  weight load and a sample that emits nothing leave the core idle, ready for the next request
//  an emitting sample goes through ST_ALIGN, ST_SUM and ST_DONE: the window copy is
//    moved up (MAX_TAPS - taps) cells, then the partial sum walks all MAX_TAPS cells
//  reset (synchronous, active low) zeros weights, history and count, num_taps = 1
//  a finished result waits in the output register; the next request is taken
//    while it waits, only the following result stalls on o_out.ready
module valid_convolution_1d_core #(
    parameter int MAX_TAPS    = vc1_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = vc1_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vc1_pkg::CFG_BITS-1:0]  i_cfg_data,
    vc1_in_if.sink                        i_in,
    vc1_out_if.source                     o_out
);
    localparam int CW = $clog2(MAX_TAPS + 1);
    localparam int RW = vc1_pkg::RESULT_BITS;
    localparam int SW = vc1_pkg::SEEN_BITS;
    localparam int PW = vc1_pkg::POS_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ALIGN = 2'd1;
    localparam logic [1:0] ST_SUM   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [vc1_pkg::CFG_BITS-1:0] r_num_taps;
    logic [1:0]                   r_state;
    logic [CW-1:0]                r_cnt;
    logic [SW-1:0]                r_seen;
    logic [PW-1:0]                r_pos;
    logic                         r_last;
    logic                         r_out_valid;
    logic signed [RW-1:0]         r_result;
    logic [PW-1:0]                r_out_pos;
    logic                         r_out_last;

    logic [CW-1:0]  taps;
    logic           in_acc;
    logic           smp_acc;
    logic           wgt_acc;
    logic [SW-1:0]  seen_inc;
    logic           emit;
    logic [SW-1:0]  pos_full;
    logic [PW-1:0]  pos_sat;
    logic           out_load;

    vc1_pkg::t_cell_ctl cell_ctl;

    logic signed [SAMPLE_BITS-1:0] cell_s    [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] cell_c    [MAX_TAPS];
    logic signed [RW-1:0]          cell_psum [MAX_TAPS];

    // tap count in use: zero acts as one, oversize clamps to the chain length
    always_comb begin
        if (r_num_taps == '0) begin
            taps = CW'(1);
        end else if (int'(r_num_taps) > MAX_TAPS) begin
            taps = CW'(MAX_TAPS);
        end else begin
            taps = CW'(r_num_taps);
        end
    end

    assign in_acc  = i_in.valid && i_in.ready;
    assign smp_acc = in_acc && i_in.func;
    // weight loads beyond the chain are dropped
    assign wgt_acc = in_acc && !i_in.func && (int'(i_in.tap_index) < MAX_TAPS);

    // frame sample count saturates, output position saturates at 16 bits
    assign seen_inc = (&r_seen) ? r_seen : r_seen + SW'(1);
    assign emit     = seen_inc >= SW'(taps);
    assign pos_full = seen_inc - SW'(taps);
    assign pos_sat  = (|pos_full[SW-1:PW]) ? '1 : pos_full[PW-1:0];

    assign i_in.ready = (r_state == ST_IDLE);
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_taps <= vc1_pkg::CFG_BITS'(1);
        end else if (i_cfg_we) begin
            r_num_taps <= i_cfg_data;
        end
    end

    // sequencer: align the window copy, let the partial sum walk, hand off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_seen  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (smp_acc) begin
                        r_seen <= i_in.frame_last ? '0 : seen_inc;
                        // weight cell q holds tap MAX_TAPS-1-q, so the window
                        // copy must sit MAX_TAPS-taps cells higher than history
                        r_cnt  <= CW'(MAX_TAPS) - taps;
                        if (emit) begin
                            r_state <= ST_ALIGN;
                        end
                    end
                end
                ST_ALIGN: begin
                    if (r_cnt == '0) begin
                        r_cnt   <= CW'(MAX_TAPS - 1);
                        r_state <= ST_SUM;
                    end else begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                ST_SUM: begin
                    if (r_cnt == '0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // position and last flag of the request in flight
    always_ff @(posedge i_clk) begin
        if (smp_acc) begin
            r_pos  <= pos_sat;
            r_last <= i_in.frame_last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_result   <= cell_psum[MAX_TAPS-1];
            r_out_pos  <= r_pos;
            r_out_last <= r_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result       = r_result;
    assign o_out.out_position = r_out_pos;
    assign o_out.out_last     = r_out_last;

    assign cell_ctl.load  = smp_acc;
    assign cell_ctl.clear = i_in.frame_last;
    assign cell_ctl.align = (r_state == ST_ALIGN) && (r_cnt != '0);

    // tap cell chain: history shifts up, window copy shifts up, partial sum
    // accumulates from cell 0 to the last cell
    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] s_prev;
        logic signed [SAMPLE_BITS-1:0] c_prev;
        logic signed [RW-1:0]          psum_prev;
        logic                          w_we;

        if (k == 0) begin : g_head
            assign s_prev    = i_in.value;
            assign c_prev    = '0;
            assign psum_prev = '0;
        end else begin : g_body
            assign s_prev    = cell_s[k-1];
            assign c_prev    = cell_c[k-1];
            assign psum_prev = cell_psum[k-1];
        end

        assign w_we = wgt_acc && (int'(i_in.tap_index) == MAX_TAPS - 1 - k);

        vc1_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl),
            .i_w_we      (w_we),
            .i_w_data    (i_in.value),
            .i_s_prev    (s_prev),
            .i_c_prev    (c_prev),
            .i_psum_prev (psum_prev),
            .o_s         (cell_s[k]),
            .o_c         (cell_c[k]),
            .o_psum      (cell_psum[k])
        );
    end
endmodule
